[rtl/pcm_pkg.sv]
// pcm_pkg: shared types, constants and colour pack/unpack functions of the
// palette colour mapper. No dependencies; used by pcm_cell and the top level.
`default_nettype none

package pcm_pkg;

  // palette slots reachable by a load, and default palette depth
  localparam int PCM_SLOTS         = 256;
  localparam int PCM_PALETTE_DEPTH = 256;

  // field widths
  localparam int PCM_IDX_W   = 8;   // palette slot index
  localparam int PCM_CNT_W   = 9;   // palette entry count
  localparam int PCM_SCORE_W = 11;  // weighted distance, at most 1275
  localparam int PCM_FMT_W   = 5;
  localparam int PCM_WORD_W  = 32;

  // palette index reported when no palette is in use (-1 in 9 bits)
  localparam logic [PCM_CNT_W-1:0] PCM_IDX_NONE = '1;

  // configuration register indexes
  localparam logic PCM_REG_FORMAT = 1'b0;
  localparam logic PCM_REG_COUNT  = 1'b1;

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_MAP_ARGB = 2'd1,
    OP_MAP_RAW  = 2'd2
  } pcm_op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } pcm_state_e;

  // pixel format codes
  typedef enum logic [PCM_FMT_W-1:0] {
    FMT_INT_ARGB8888 = 5'd0,
    FMT_INT_BGRA8888 = 5'd1,
    FMT_INT_BGRX8888 = 5'd2,
    FMT_INT_BGR888   = 5'd3,
    FMT_INT_RGBX8888 = 5'd4,
    FMT_INT_RGB888   = 5'd5,
    FMT_BYTE3_RGB888 = 5'd6,
    FMT_BYTE3_BGR888 = 5'd7,
    FMT_ARGB4444     = 5'd8,
    FMT_RGB565       = 5'd9,
    FMT_RGB555       = 5'd10,
    FMT_ABGR1555     = 5'd11,
    FMT_INDEXED65536 = 5'd12,
    FMT_INDEXED256   = 5'd13,
    FMT_INDEXED4     = 5'd14,
    FMT_INDEXED2     = 5'd15,
    FMT_INDEXED1     = 5'd16
  } pcm_fmt_e;

  // token handed from cell to cell along the palette chain
  typedef struct packed {
    logic                   vld;
    logic                   lookup;     // fetch pass rather than search pass
    logic [PCM_IDX_W-1:0]   target;     // slot fetched by a fetch pass
    logic [PCM_WORD_W-1:0]  word;       // ARGB colour being mapped
    logic [2:0]             wmask;      // red/green/blue weigh 1 when set
    logic                   exact;
    logic [PCM_IDX_W-1:0]   best_idx;
    logic [PCM_SCORE_W-1:0] best_score;
  } pcm_token_t;

  // palette write broadcast to all cells
  typedef struct packed {
    logic                  we;
    logic [PCM_IDX_W-1:0]  idx;
    logic [PCM_WORD_W-1:0] data;
  } pcm_load_t;

  // channels that are maximal in the colour weigh 1, the rest 2
  function automatic logic [2:0] pcm_weights(input logic [PCM_WORD_W-1:0] w);
    logic [7:0] r, g, b;
    r = w[23:16];
    g = w[15:8];
    b = w[7:0];
    return {(r >= g) && (r >= b), (g >= r) && (g >= b), (b >= r) && (b >= g)};
  endfunction

  // raw pixel to ARGB word, by format
  function automatic logic [PCM_WORD_W-1:0] pcm_decode(input logic [PCM_FMT_W-1:0] fmt,
                                                      input logic [PCM_WORD_W-1:0] v);
    logic [PCM_WORD_W-1:0] w;
    w = '0;
    case (fmt) inside
      FMT_INT_ARGB8888: w = v;
      FMT_INT_BGRA8888: w = {v[7:0], v[15:8], v[23:16], v[31:24]};
      FMT_INT_BGRX8888: w = {8'hFF, v[15:8], v[23:16], v[31:24]};
      FMT_INT_BGR888, FMT_BYTE3_BGR888: w = {8'hFF, v[7:0], v[15:8], v[23:16]};
      FMT_INT_RGB888, FMT_BYTE3_RGB888: w = {8'hFF, v[23:16], v[15:8], v[7:0]};
      FMT_INT_RGBX8888: w = {8'hFF, v[31:24], v[23:16], v[15:8]};
      FMT_ARGB4444: w = {v[15:12], v[15:12], v[11:8], v[11:8],
                         v[7:4], v[7:4], v[3:0], v[3:0]};
      FMT_RGB565: w = {8'hFF, v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
      FMT_RGB555: w = {8'hFF, v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
      default: w = '0;
    endcase
    return w;
  endfunction

  // ARGB word and palette index to packed pixel, by format
  function automatic logic [PCM_WORD_W-1:0] pcm_pack(input logic [PCM_FMT_W-1:0] fmt,
                                                    input logic [PCM_WORD_W-1:0] w,
                                                    input logic [PCM_CNT_W-1:0]  idx);
    logic [7:0] a, r, g, b;
    logic [PCM_WORD_W-1:0] ix;
    logic [PCM_WORD_W-1:0] p;
    a  = w[31:24];
    r  = w[23:16];
    g  = w[15:8];
    b  = w[7:0];
    ix = {{(PCM_WORD_W-PCM_CNT_W){idx[PCM_CNT_W-1]}}, idx};
    p  = '0;
    case (fmt)
      FMT_INT_ARGB8888: p = w;
      FMT_INT_BGRA8888: p = {b, g, r, a};
      FMT_INT_BGRX8888: p = {b, g, r, 8'hFF};
      FMT_INT_BGR888:   p = {8'hFF, b, g, r};
      FMT_INT_RGBX8888: p = {r, g, b, 8'hFF};
      FMT_INT_RGB888:   p = {8'hFF, w[23:0]};
      FMT_BYTE3_RGB888: p = {8'h00, r, g, b};
      FMT_BYTE3_BGR888: p = {8'h00, b, g, r};
      FMT_ARGB4444:     p = {16'h0000, a[7:4], r[7:4], g[7:4], b[7:4]};
      FMT_RGB565:       p = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_RGB555:       p = {17'h00000, r[7:3], g[7:3], b[7:3]};
      FMT_ABGR1555:     p = {16'h0000, a[7], b[7:3], g[7:3], r[7:3]};
      FMT_INDEXED65536: p = {16'h0000, ix[15:0]};
      FMT_INDEXED256:   p = {24'h000000, ix[7:0]};
      FMT_INDEXED4:     p = {28'h0000000, ix[3:0]};
      FMT_INDEXED2:     p = {30'h00000000, ix[1:0]};
      FMT_INDEXED1:     p = {31'h00000000, ix[0]};
      default:          p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/pcm_cell.sv]
// pcm_cell: one palette slot of the search chain; holds one palette word and
// registers the travelling token each cycle. Depends on pcm_pkg.
`default_nettype none

module pcm_cell
  import pcm_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcm_load_t            load_i,
  input  logic [PCM_CNT_W-1:0] active_n_i,
  input  pcm_token_t           tok_i,
  output pcm_token_t           tok_o
);

  localparam logic [PCM_IDX_W-1:0] MyIdx = PCM_IDX_W'(CELL_ID);
  localparam logic [PCM_CNT_W-1:0] MyPos = PCM_CNT_W'(CELL_ID);

  logic [PCM_WORD_W-1:0]  entry_q;
  pcm_token_t             tok_d, tok_q;
  logic [7:0]             dr, dg, db;
  logic [8:0]             sr, sg, sb;
  logic [PCM_SCORE_W-1:0] score;

  function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  // palette word, written by a load to this slot
  always_ff @(posedge clk_i) begin
    if (load_i.we && (load_i.idx == MyIdx)) begin
      entry_q <= load_i.data;
    end
  end

  // weighted distance of this entry from the token colour
  always_comb begin
    dr    = absdiff(entry_q[23:16], tok_i.word[23:16]);
    dg    = absdiff(entry_q[15:8], tok_i.word[15:8]);
    db    = absdiff(entry_q[7:0], tok_i.word[7:0]);
    sr    = tok_i.wmask[2] ? {1'b0, dr} : {dr, 1'b0};
    sg    = tok_i.wmask[1] ? {1'b0, dg} : {dg, 1'b0};
    sb    = tok_i.wmask[0] ? {1'b0, db} : {db, 1'b0};
    score = PCM_SCORE_W'(sr) + PCM_SCORE_W'(sg) + PCM_SCORE_W'(sb);
  end

  // fetch or compare, then hand on
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld) begin
      if (tok_i.lookup) begin
        if (tok_i.target == MyIdx) begin
          tok_d.word = entry_q;
        end
      end else if ((MyPos < active_n_i) && !tok_i.exact) begin
        if (entry_q[23:0] == tok_i.word[23:0]) begin
          tok_d.exact    = 1'b1;
          tok_d.best_idx = MyIdx;
        end else if (score < tok_i.best_score) begin
          tok_d.best_idx   = MyIdx;
          tok_d.best_score = score;
        end
      end
    end
  end

  // token register, only the valid bit is cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[rtl/palette_color_mapper_unit.sv]
// palette_color_mapper_unit: top level; control, configuration, result
// packing and the chain of pcm_cell slots. Depends on pcm_pkg and pcm_cell.
//
// One item is in work at a time. A load writes its slot and gives no result.
// A map with no palette in use passes the result register and then the
// output register. With a palette, a token walks the chain of min(PALETTE_DEPTH, 256)
// cells, one cell per cycle, so a map from ARGB (or a raw value outside the
// palette) takes one walk, and a raw value inside the palette takes two
// walks (fetch, then search), before the result and output registers. The finished result
// sits in an output register, so the next item is taken while it waits.
`default_nettype none

module palette_color_mapper_unit
  import pcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = PCM_PALETTE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [PCM_WORD_W-1:0]       value_i,
  input  logic [PCM_IDX_W-1:0]        entry_index_i,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [PCM_CNT_W-1:0]        cfg_wdata_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  alpha_o,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic signed [PCM_CNT_W-1:0] palette_index_o,
  output logic [PCM_WORD_W-1:0]       pixel_value_o,
  output logic [PCM_WORD_W-1:0]       color_word_o
);

  localparam int CellCount = (PALETTE_DEPTH < PCM_SLOTS) ? PALETTE_DEPTH : PCM_SLOTS;
  localparam logic [PCM_CNT_W-1:0] CountCap = PCM_CNT_W'(CellCount);

  pcm_state_e             state_q, state_d;
  logic [PCM_FMT_W-1:0]   format_q;
  logic [PCM_CNT_W-1:0]   count_q;
  logic [PCM_CNT_W-1:0]   active_n;
  logic [PCM_WORD_W-1:0]  res_word_q, res_word_d;
  logic [PCM_CNT_W-1:0]   res_idx_q, res_idx_d;
  logic                   out_vld_q;
  logic                   out_load;
  logic                   raw_hit;
  pcm_load_t              load;
  pcm_token_t             inj;
  pcm_token_t             chain [CellCount+1];
  pcm_token_t             last;
  logic [CellCount-1:0]   chain_vld;

  function automatic pcm_token_t scan_token(input logic [PCM_WORD_W-1:0] w);
    pcm_token_t t;
    t            = '0;
    t.vld        = 1'b1;
    t.word       = w;
    t.wmask      = pcm_weights(w);
    t.best_score = '1;
    return t;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= '0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == PCM_REG_FORMAT) begin
        format_q <= cfg_wdata_i[PCM_FMT_W-1:0];
      end else begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  assign active_n = (count_q > CountCap) ? CountCap : count_q;
  assign raw_hit  = (value_i[PCM_WORD_W-1:PCM_CNT_W] == '0) &&
                    (value_i[PCM_CNT_W-1:0] < active_n);
  assign last     = chain[CellCount];

  // control: next state, token injection, palette writes
  always_comb begin
    state_d    = state_q;
    res_word_d = res_word_q;
    res_idx_d  = res_idx_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    inj        = '0;
    load.we    = 1'b0;
    load.idx   = entry_index_i;
    load.data  = value_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_LOAD: begin
              load.we = 1'b1;
            end
            OP_MAP_ARGB: begin
              if (active_n == '0) begin
                res_word_d = value_i;
                res_idx_d  = PCM_IDX_NONE;
                state_d    = ST_DONE;
              end else begin
                inj     = scan_token(value_i);
                state_d = ST_SCAN;
              end
            end
            OP_MAP_RAW: begin
              if (active_n == '0) begin
                res_word_d = pcm_decode(format_q, value_i);
                res_idx_d  = PCM_IDX_NONE;
                state_d    = ST_DONE;
              end else if (raw_hit) begin
                inj.vld    = 1'b1;
                inj.lookup = 1'b1;
                inj.target = value_i[PCM_IDX_W-1:0];
                state_d    = ST_LOOKUP;
              end else begin
                inj     = scan_token('0);
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (last.vld) begin
          inj     = scan_token(last.word);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last.vld) begin
          res_word_d = last.word;
          res_idx_d  = {1'b0, last.best_idx};
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // finished colour and index, waiting for the output register
  always_ff @(posedge clk_i) begin
    res_word_q <= res_word_d;
    res_idx_q  <= res_idx_d;
  end

  // palette chain
  assign chain[0] = inj;

  for (genvar c = 0; c < CellCount; c++) begin : g_cell
    pcm_cell #(
      .CELL_ID(c)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .active_n_i (active_n),
      .tok_i      (chain[c]),
      .tok_o      (chain[c+1])
    );
    assign chain_vld[c] = chain[c+1].vld;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload, packed on the way in
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      alpha_o         <= res_word_q[31:24];
      red_o           <= res_word_q[23:16];
      green_o         <= res_word_q[15:8];
      blue_o          <= res_word_q[7:0];
      palette_index_o <= res_idx_q;
      pixel_value_o   <= pcm_pack(format_q, res_word_q, res_idx_q);
      color_word_o    <= res_word_q;
    end
  end

  assign out_valid_o = out_vld_q;

  // at most one token walks the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(chain_vld))
    else $error("more than one token in the palette chain");

  // a token only leaves the chain while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.vld |-> (state_q == ST_LOOKUP || state_q == ST_SCAN))
    else $error("token left the chain with no pass in progress");

  // a finished search always names an entry in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.vld && !last.lookup) |-> ({1'b0, last.best_idx} < active_n))
    else $error("search ended on an entry outside the palette");

endmodule

`default_nettype wire

[test/palette_color_mapper_unit_tb.sv]
// palette_color_mapper_unit_tb: self-checking bench for the palette colour mapper,
// with a behavioural predictor, a queued item driver and a result monitor.
// Depends on pcm_pkg and the palette_color_mapper_unit RTL only.

module palette_color_mapper_unit_tb;
  import pcm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime     CLK_PERIOD       = 8ns;
  localparam int unsigned RUN_LIMIT_CYCLES = 4_000_000;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned PHASE_SETTLE     = 8;    // pause for a trailing load or ignored item
  localparam int unsigned END_SETTLE       = 600;  // longer than a fetch plus a search walk
  localparam int unsigned PHASE_ITEMS      = 85;

  // opcode the block drops without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // highest format code, beyond the defined ones
  localparam logic [PCM_FMT_W-1:0] FMT_CODE_MAX = 5'd31;

  // idling modes
  localparam int unsigned IDLE_NONE     = 0;
  localparam int unsigned IDLE_SENDER   = 1;
  localparam int unsigned IDLE_RECEIVER = 2;
  localparam int unsigned IDLE_BOTH     = 3;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [PCM_WORD_W-1:0] value;
    logic [PCM_IDX_W-1:0]  entry_index;
  } mapper_item_t;

  typedef struct packed {
    logic [7:0]            alpha;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [PCM_CNT_W-1:0]  palette_index;
    logic [PCM_WORD_W-1:0] pixel_value;
    logic [PCM_WORD_W-1:0] color_word;
  } mapped_pixel_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  opcode_i      = '0;
  logic [PCM_WORD_W-1:0]       value_i       = '0;
  logic [PCM_IDX_W-1:0]        entry_index_i = '0;
  logic                        cfg_we_i      = 1'b0;
  logic                        cfg_index_i   = 1'b0;
  logic [PCM_CNT_W-1:0]        cfg_wdata_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic [7:0]                  alpha_o;
  logic [7:0]                  red_o;
  logic [7:0]                  green_o;
  logic [7:0]                  blue_o;
  logic signed [PCM_CNT_W-1:0] palette_index_o;
  logic [PCM_WORD_W-1:0]       pixel_value_o;
  logic [PCM_WORD_W-1:0]       color_word_o;

  // pending transfers, and mapped pixels still owed by the block
  mapper_item_t  pending_items[$];
  mapped_pixel_t owed_pixels[$];

  // predictor state
  logic [PCM_WORD_W-1:0] palette_model[PCM_SLOTS];
  logic [PCM_FMT_W-1:0]  model_format = '0;
  logic [PCM_CNT_W-1:0]  model_count  = '0;

  // palette words as queued, used to aim colours at entries
  logic [PCM_WORD_W-1:0] slot_word[PCM_SLOTS];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned pixels_checked = 0;
  int unsigned loads_done     = 0;
  int unsigned maps_done      = 0;
  int unsigned ignored_done   = 0;
  int unsigned settings_used  = 0;

  palette_color_mapper_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .entry_index_i  (entry_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .alpha_o        (alpha_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .palette_index_o(palette_index_o),
    .pixel_value_o  (pixel_value_o),
    .color_word_o   (color_word_o)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor

  function automatic int unsigned entries_in_use(input logic [PCM_CNT_W-1:0] count);
    return (count > PCM_PALETTE_DEPTH) ? PCM_PALETTE_DEPTH : int'(count);
  endfunction

  function automatic int unsigned channel_gap(input logic [7:0] x, input logic [7:0] y);
    return (x >= y) ? int'(x - y) : int'(y - x);
  endfunction

  // raw pixel to ARGB when no palette is in use
  function automatic logic [PCM_WORD_W-1:0] unpack_raw(input logic [PCM_WORD_W-1:0] v);
    logic [7:0] a, r, g, b;
    a = '0;
    r = '0;
    g = '0;
    b = '0;
    case (model_format)
      FMT_INT_ARGB8888: {a, r, g, b} = v;
      FMT_INT_BGRA8888: {b, g, r, a} = v;
      FMT_INT_BGRX8888: begin
        {b, g, r} = v[31:8];
        a = 8'hFF;
      end
      FMT_INT_BGR888, FMT_BYTE3_BGR888: begin
        {b, g, r} = v[23:0];
        a = 8'hFF;
      end
      FMT_INT_RGB888, FMT_BYTE3_RGB888: begin
        {r, g, b} = v[23:0];
        a = 8'hFF;
      end
      FMT_INT_RGBX8888: begin
        {r, g, b} = v[31:8];
        a = 8'hFF;
      end
      FMT_ARGB4444: begin
        a = {2{v[15:12]}};
        r = {2{v[11:8]}};
        g = {2{v[7:4]}};
        b = {2{v[3:0]}};
      end
      FMT_RGB565: begin
        a = 8'hFF;
        r = {v[15:11], 3'b000};
        g = {v[10:5], 2'b00};
        b = {v[4:0], 3'b000};
      end
      FMT_RGB555: begin
        a = 8'hFF;
        r = {v[14:10], 3'b000};
        g = {v[9:5], 3'b000};
        b = {v[4:0], 3'b000};
      end
      default: ;  // indexed, ABGR1555 and unknown codes give zero
    endcase
    return {a, r, g, b};
  endfunction

  // nearest palette entry, then packing for the current format
  function automatic mapped_pixel_t map_colour(input logic [PCM_WORD_W-1:0] argb);
    mapped_pixel_t         res;
    logic [7:0]            a, r, g, b;
    logic [PCM_CNT_W-1:0]  idx;
    logic [PCM_WORD_W-1:0] ix, px, entry;
    int unsigned           n, wr, wg, wb, score, best_score, i;
    bit                    hit;
    {a, r, g, b} = argb;
    n   = entries_in_use(model_count);
    idx = PCM_IDX_NONE;
    if (n != 0) begin
      wr = (r >= g && r >= b) ? 1 : 2;
      wg = (g >= r && g >= b) ? 1 : 2;
      wb = (b >= r && b >= g) ? 1 : 2;
      best_score = 32'hFFFF_FFFF;
      idx = '0;
      hit = 1'b0;
      for (i = 0; i < n && !hit; i++) begin
        entry = palette_model[i];
        if (entry[23:0] == argb[23:0]) begin
          idx = PCM_CNT_W'(i);
          hit = 1'b1;
        end else begin
          score = channel_gap(entry[23:16], r) * wr + channel_gap(entry[15:8], g) * wg
                + channel_gap(entry[7:0], b) * wb;
          // strict compare keeps the first of equal scores
          if (score < best_score) begin
            best_score = score;
            idx = PCM_CNT_W'(i);
          end
        end
      end
    end
    ix = {{(PCM_WORD_W - PCM_CNT_W){idx[PCM_CNT_W-1]}}, idx};
    case (model_format)
      FMT_INT_ARGB8888: px = argb;
      FMT_INT_BGRA8888: px = {b, g, r, a};
      FMT_INT_BGRX8888: px = {b, g, r, 8'hFF};
      FMT_INT_BGR888:   px = {8'hFF, b, g, r};
      FMT_INT_RGBX8888: px = {r, g, b, 8'hFF};
      FMT_INT_RGB888:   px = argb | 32'hFF00_0000;
      FMT_BYTE3_RGB888: px = {8'h00, r, g, b};
      FMT_BYTE3_BGR888: px = {8'h00, b, g, r};
      FMT_ARGB4444:     px = {16'h0, a[7:4], r[7:4], g[7:4], b[7:4]};
      FMT_RGB565:       px = {16'h0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB555:       px = {17'h0, r[7:3], g[7:3], b[7:3]};
      FMT_ABGR1555:     px = {16'h0, a[7], b[7:3], g[7:3], r[7:3]};
      FMT_INDEXED65536: px = ix & 32'h0000_FFFF;
      FMT_INDEXED256:   px = ix & 32'h0000_00FF;
      FMT_INDEXED4:     px = ix & 32'h0000_000F;
      FMT_INDEXED2:     px = ix & 32'h0000_0003;
      FMT_INDEXED1:     px = ix & 32'h0000_0001;
      default:          px = '0;
    endcase
    res.alpha         = a;
    res.red           = r;
    res.green         = g;
    res.blue          = b;
    res.palette_index = idx;
    res.pixel_value   = px;
    res.color_word    = argb;
    return res;
  endfunction

  // update the model for one accepted item and note what the block owes
  function automatic void predict_item(input mapper_item_t it);
    int unsigned n;
    n = entries_in_use(model_count);
    case (it.opcode)
      OP_LOAD: begin
        palette_model[it.entry_index] = it.value;
        loads_done++;
      end
      OP_MAP_ARGB: begin
        owed_pixels.push_back(map_colour(it.value));
        maps_done++;
      end
      OP_MAP_RAW: begin
        if (n == 0)
          owed_pixels.push_back(map_colour(unpack_raw(it.value)));
        else if (it.value < n)
          owed_pixels.push_back(map_colour(palette_model[it.value[PCM_IDX_W-1:0]]));
        else
          owed_pixels.push_back(map_colour('0));
        maps_done++;
      end
      default: ignored_done++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver and monitor

  // item driver: presents the next pending item once the bus is free
  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    mapper_item_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= '0;
      value_i       <= '0;
      entry_index_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        predict_item({opcode_i, value_i, entry_index_i});
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= nxt.opcode;
          value_i       <= nxt.value;
          entry_index_i <= nxt.entry_index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each transfer with the oldest owed pixel
  always @(posedge clk_i or negedge rst_ni) begin : pixel_monitor
    mapped_pixel_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {alpha_o, red_o, green_o, blue_o, palette_index_o, pixel_value_o, color_word_o};
        if (owed_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%t: result transfer with nothing owed: %p", $realtime, got);
        end else begin
          want = owed_pixels.pop_front();
          pixels_checked++;
          if (got.alpha !== want.alpha || got.red !== want.red || got.green !== want.green
              || got.blue !== want.blue || got.palette_index !== want.palette_index
              || got.pixel_value !== want.pixel_value || got.color_word !== want.color_word)
          begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%t: mismatch, expected a=%h r=%h g=%h b=%h idx=%h pixel=%h word=%h",
                       $realtime, want.alpha, want.red, want.green, want.blue,
                       want.palette_index, want.pixel_value, want.color_word);
              $display("%t:           actual a=%h r=%h g=%h b=%h idx=%h pixel=%h word=%h",
                       $realtime, got.alpha, got.red, got.green, got.blue,
                       got.palette_index, got.pixel_value, got.color_word);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  function automatic void queue_item(input logic [1:0] op, input logic [PCM_WORD_W-1:0] v,
                                     input logic [PCM_IDX_W-1:0] slot);
    mapper_item_t it;
    it.opcode      = op;
    it.value       = v;
    it.entry_index = slot;
    if (op == OP_LOAD)
      slot_word[slot] = v;
    pending_items.push_back(it);
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    return (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
  endfunction

  // colour aimed at the palette in use: exact hits, near misses, tied channels
  function automatic logic [PCM_WORD_W-1:0] pick_colour(input int unsigned n);
    logic [PCM_WORD_W-1:0] c;
    c = $urandom;
    if (n != 0) begin
      case ($urandom_range(9))
        0, 1, 2: c[23:0] = slot_word[$urandom_range(n - 1)][23:0];
        3, 4: begin
          c[23:0]  = slot_word[$urandom_range(n - 1)][23:0];
          c[23:16] = nudge(c[23:16]);
          c[15:8]  = nudge(c[15:8]);
          c[7:0]   = nudge(c[7:0]);
        end
        default: ;
      endcase
    end
    if ($urandom_range(6) == 0) begin
      c[15:8] = c[23:16];
      if ($urandom_range(1) != 0)
        c[7:0] = c[23:16];
    end
    return c;
  endfunction

  function automatic void queue_random_item(input int unsigned n);
    int unsigned           pick;
    logic [PCM_WORD_W-1:0] w;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // palette load, sometimes repeating another entry's colour
      w = $urandom;
      case ($urandom_range(3))
        0: w[23:0] = slot_word[$urandom_range(PCM_SLOTS - 1)][23:0];
        1: w[23:0] = {3{w[7:0]}};
        default: ;
      endcase
      queue_item(OP_LOAD, w, PCM_IDX_W'($urandom));
    end else if (pick < 20) begin
      queue_item(OP_UNUSED, $urandom, PCM_IDX_W'($urandom));
    end else if (pick < 62) begin
      queue_item(OP_MAP_ARGB, pick_colour(n), PCM_IDX_W'($urandom));
    end else begin
      // raw pixel: mostly inside the palette, some at or past its end
      if (n != 0 && $urandom_range(3) != 0)
        w = $urandom_range(n - 1);
      else if (n != 0 && $urandom_range(1) != 0)
        w = $urandom_range(n + 2);
      else
        w = $urandom;
      queue_item(OP_MAP_RAW, w, PCM_IDX_W'($urandom));
    end
  endfunction

  task automatic write_config(input logic [PCM_FMT_W-1:0] fmt,
                              input logic [PCM_CNT_W-1:0] count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= PCM_REG_FORMAT;
    cfg_wdata_i <= PCM_CNT_W'(fmt);
    @(posedge clk_i);
    cfg_index_i <= PCM_REG_COUNT;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_format = fmt;
    model_count  = count;
    settings_used++;
    @(negedge clk_i);
  endtask

  // all items transferred and all pixels returned, then a short pause
  task automatic wait_idle(input int unsigned settle);
    do
      @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || owed_pixels.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct  = 52;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 52;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 17;
        recv_stall_pct = 17;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic run_phase(input logic [PCM_FMT_W-1:0] fmt, input logic [PCM_CNT_W-1:0] count,
                           input int unsigned mode);
    int unsigned n;
    set_idling(mode);
    write_config(fmt, count);
    n = entries_in_use(count);
    repeat (PHASE_ITEMS) queue_random_item(n);
    wait_idle(PHASE_SETTLE);
  endtask

  // main sequence
  initial begin : main_sequence
    int unsigned           p;
    logic [PCM_FMT_W-1:0]  fmt;
    logic [PCM_CNT_W-1:0]  count;
    logic [PCM_WORD_W-1:0] w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(IDLE_NONE);

    // indexed format with no palette: index all ones, raw decodes to zero
    write_config(FMT_INDEXED256, '0);
    queue_item(OP_MAP_ARGB, 32'h1234_5678, '0);
    queue_item(OP_MAP_RAW, 32'h0000_0055, '0);
    queue_item(OP_MAP_ARGB, 32'h0000_0000, '0);
    wait_idle(PHASE_SETTLE);

    // raw ABGR1555 is not decoded
    write_config(FMT_ABGR1555, '0);
    queue_item(OP_MAP_RAW, 32'hFFFF_FFFF, '0);
    queue_item(OP_MAP_ARGB, 32'h80FF_8040, '0);
    wait_idle(PHASE_SETTLE);

    // RGB565 raw decode, green from bits 10..5
    write_config(FMT_RGB565, '0);
    queue_item(OP_MAP_RAW, 32'h0000_07E0, '0);
    queue_item(OP_MAP_RAW, 32'h0000_F81F, '0);
    queue_item(OP_MAP_ARGB, 32'hFFFF_FFFF, '0);
    wait_idle(PHASE_SETTLE);

    // unknown format code, the unused opcode and the first palette loads
    write_config(FMT_CODE_MAX, '0);
    queue_item(OP_MAP_ARGB, 32'hFFFF_FFFF, '0);
    queue_item(OP_MAP_RAW, 32'hFFFF_FFFF, '0);
    queue_item(OP_UNUSED, 32'hFFFF_FFFF, '1);
    queue_item(OP_LOAD, 32'hFF10_2030, 8'd0);
    queue_item(OP_LOAD, 32'h0010_2030, 8'd1);
    queue_item(OP_LOAD, 32'hFFFF_FFFF, 8'd2);
    queue_item(OP_LOAD, 32'h0000_0000, 8'd3);
    queue_item(OP_LOAD, 32'hFFFF_FFFF, '1);
    wait_idle(PHASE_SETTLE);

    // small palette: exact hit before a duplicate, nearest search, raw lookups
    write_config(FMT_INDEXED4, 9'd4);
    queue_item(OP_MAP_ARGB, 32'h0010_2030, '0);
    queue_item(OP_MAP_ARGB, 32'hAB80_8080, '0);
    queue_item(OP_MAP_ARGB, 32'hFF00_FF00, '0);
    queue_item(OP_MAP_RAW, 32'h0000_0000, '0);
    queue_item(OP_MAP_RAW, 32'h0000_0003, '0);
    queue_item(OP_MAP_RAW, 32'h0000_0004, '0);
    queue_item(OP_MAP_RAW, 32'hFFFF_FFFF, '0);
    wait_idle(PHASE_SETTLE);

    // fill every palette slot, some colours repeated
    write_config(FMT_INT_RGB888, '0);
    for (p = 0; p < PCM_SLOTS; p++) begin
      w = $urandom;
      if (p != 0 && $urandom_range(7) == 0)
        w[23:0] = slot_word[$urandom_range(p - 1)][23:0];
      queue_item(OP_LOAD, w, PCM_IDX_W'(p));
    end
    wait_idle(PHASE_SETTLE);

    // random phases over formats, palette sizes and idling modes
    for (p = 0; p < 12; p++) begin
      case (p)
        0: begin fmt = FMT_INDEXED256;   count = PCM_CNT_W'(PCM_PALETTE_DEPTH); end
        1: begin fmt = FMT_RGB565;       count = 9'd1;              end
        2: begin fmt = FMT_INDEXED65536; count = '1;                end  // oversized count
        3: begin fmt = FMT_INDEXED1;     count = 9'd2;              end
        4: begin fmt = FMT_ABGR1555;     count = '0;                end
        5: begin fmt = FMT_CODE_MAX;     count = PCM_CNT_W'(PCM_PALETTE_DEPTH); end
        6: begin
          fmt   = FMT_INDEXED2;
          count = PCM_CNT_W'($urandom_range(1, PCM_PALETTE_DEPTH));
        end
        7: begin fmt = FMT_ARGB4444;     count = '0;                end
        default: begin
          fmt = PCM_FMT_W'($urandom_range(FMT_INDEXED1 + 4));
          case ($urandom_range(3))
            0:       count = '0;
            1:       count = PCM_CNT_W'(PCM_PALETTE_DEPTH);
            default: count = PCM_CNT_W'($urandom_range(PCM_PALETTE_DEPTH));
          endcase
        end
      endcase
      run_phase(fmt, count, p % 4);
    end

    wait_idle(END_SETTLE);
    if (owed_pixels.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", owed_pixels.size());
    end
    $display("run covered %0d loads, %0d maps and %0d dropped items over %0d register settings",
             loads_done, maps_done, ignored_done, settings_used);
    $display("%0d results compared, %0d mismatching", pixels_checked, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("timeout with %0d items pending and %0d results owed",
             pending_items.size(), owed_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/pcm_pkg.sv
rtl/pcm_cell.sv
rtl/palette_color_mapper_unit.sv
test/palette_color_mapper_unit_tb.sv
